### hw/rtl/iffa_pkg.sv
// Package for the first-fit heap allocator core.
// Holds sizing constants, controller state type and the command/status structs.
// No dependencies.
`default_nettype none

package iffa_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int MAX_REQUEST = 4096;

  localparam int STORE_DEPTH = HEAP_BYTES / 8;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int UNIT_W      = $clog2(STORE_DEPTH + 1);
  localparam int NEED_W      = $clog2(MAX_REQUEST / 8 + 1);
  localparam int WORD_W      = IDX_W + 1;
  localparam int CMP_W       = ((NEED_W > UNIT_W) ? NEED_W : UNIT_W) + 2;

  localparam int REQ_W       = 16;
  localparam int ADDR_W      = 12;
  localparam int HEAP_W      = 13;
  localparam int CFG_DATA_W  = 16;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 16;

  typedef enum logic [2:0] {
    ST_FMT,
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_SPLIT,
    ST_FREE_WR,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic cfg_load;
    logic take_item;
    logic fmt_wr;
    logic walk_first;
    logic walk_next;
    logic hit_wr;
    logic split_wr;
    logic free_rd;
    logic free_wr;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic is_free;
    logic req_ok;
    logic free_ok;
    logic fit;
    logic split;
    logic last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hw/rtl/iffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module iffa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/iffa_ctrl.sv
// Controller state machine of the first-fit allocator.
// Depends on iffa_pkg (state enum, command and status structs).
`default_nettype none

module iffa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  wire logic               cfg_valid_i,
  input  wire iffa_pkg::ctrl_sts_t sts_i,
  output iffa_pkg::ctrl_cmd_t     cmd_o,
  output logic                    s_ready_o,
  output logic                    cfg_ready_o
);

  iffa_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iffa_pkg::ST_FMT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      iffa_pkg::ST_FMT: begin
        state_d = iffa_pkg::ST_IDLE;
      end
      iffa_pkg::ST_IDLE: begin
        if (cfg_valid_i) begin
          if (sts_i.cfg_ok) begin
            state_d = iffa_pkg::ST_FMT;
          end
        end else if (s_valid_i) begin
          state_d = iffa_pkg::ST_START;
        end
      end
      iffa_pkg::ST_START: begin
        if (sts_i.is_free) begin
          state_d = sts_i.free_ok ? iffa_pkg::ST_FREE_WR : iffa_pkg::ST_RESP;
        end else begin
          state_d = sts_i.req_ok ? iffa_pkg::ST_WALK : iffa_pkg::ST_RESP;
        end
      end
      iffa_pkg::ST_WALK: begin
        if (sts_i.fit) begin
          state_d = sts_i.split ? iffa_pkg::ST_SPLIT : iffa_pkg::ST_RESP;
        end else if (sts_i.last) begin
          state_d = iffa_pkg::ST_RESP;
        end
      end
      iffa_pkg::ST_SPLIT: begin
        state_d = iffa_pkg::ST_RESP;
      end
      iffa_pkg::ST_FREE_WR: begin
        state_d = iffa_pkg::ST_RESP;
      end
      iffa_pkg::ST_RESP: begin
        if (sts_i.out_free) begin
          state_d = iffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      iffa_pkg::ST_FMT: begin
        cmd_o.fmt_wr = 1'b1;
      end
      iffa_pkg::ST_IDLE: begin
        cfg_ready_o     = 1'b1;
        s_ready_o       = !cfg_valid_i;
        cmd_o.cfg_load  = cfg_valid_i;
        cmd_o.take_item = !cfg_valid_i && s_valid_i;
      end
      iffa_pkg::ST_START: begin
        cmd_o.free_rd    = sts_i.is_free && sts_i.free_ok;
        cmd_o.walk_first = !sts_i.is_free && sts_i.req_ok;
      end
      iffa_pkg::ST_WALK: begin
        cmd_o.hit_wr    = sts_i.fit;
        cmd_o.walk_next = !sts_i.fit && !sts_i.last;
      end
      iffa_pkg::ST_SPLIT: begin
        cmd_o.split_wr = 1'b1;
      end
      iffa_pkg::ST_FREE_WR: begin
        cmd_o.free_wr = 1'b1;
      end
      iffa_pkg::ST_RESP: begin
        cmd_o.load_result = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/iffa_dp.sv
// Datapath of the first-fit allocator: heap size, item registers, header walk
// arithmetic, header RAM and result register. Depends on iffa_pkg, iffa_ram.
`default_nettype none

module iffa_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire iffa_pkg::ctrl_cmd_t             cmd_i,
  output iffa_pkg::ctrl_sts_t                  sts_o,
  input  wire logic [iffa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            action_i,
  input  wire logic [iffa_pkg::REQ_W-1:0]      request_size_i,
  input  wire logic [iffa_pkg::ADDR_W-1:0]     block_address_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [iffa_pkg::ADDR_W-1:0]          granted_address_o,
  output logic                                 granted_o
);

  localparam int IDX_W  = iffa_pkg::IDX_W;
  localparam int UNIT_W = iffa_pkg::UNIT_W;
  localparam int CMP_W  = iffa_pkg::CMP_W;
  localparam int WORD_W = iffa_pkg::WORD_W;
  localparam int NEED_W = iffa_pkg::NEED_W;
  localparam int REQ_W  = iffa_pkg::REQ_W;
  localparam int ADDR_W = iffa_pkg::ADDR_W;
  localparam int CU_W   = iffa_pkg::HEAP_W - 3;

  logic [UNIT_W-1:0] heap_q;
  logic              act_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [UNIT_W-1:0] cur_q;
  logic              grant_q;
  logic [IDX_W-1:0]  rem_q;
  logic [IDX_W-1:0]  nidx_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_grant_q;

  logic [CU_W-1:0]   cfg_u;
  logic [UNIT_W-1:0] cfg_clip;
  logic [REQ_W:0]    req_rnd;
  logic [NEED_W-1:0] need_u;
  logic [WORD_W-1:0] rd_word;
  logic [IDX_W-1:0]  payload;
  logic [CMP_W-1:0]  next_u;
  logic [CMP_W-1:0]  nidx_w;
  logic [CMP_W-1:0]  rem_w;
  logic [ADDR_W-4:0] addr_u;
  logic [CMP_W-1:0]  hdr_w;
  logic [CMP_W+2:0]  gaddr;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [IDX_W-1:0]  raddr;

  assign cfg_u    = cfg_data_i[iffa_pkg::HEAP_W-1:3];
  assign cfg_clip = (CMP_W'(cfg_u) > CMP_W'(iffa_pkg::STORE_DEPTH))
                    ? UNIT_W'(iffa_pkg::STORE_DEPTH) : UNIT_W'(cfg_u);

  assign req_rnd = {1'b0, req_q} + (REQ_W + 1)'(7);
  assign need_u  = NEED_W'(req_rnd >> 3);

  assign payload = rd_word[WORD_W-1:1];
  assign next_u  = CMP_W'(cur_q) + CMP_W'(1) + CMP_W'(payload);
  assign nidx_w  = CMP_W'(cur_q) + CMP_W'(1) + CMP_W'(need_u);
  assign rem_w   = CMP_W'(payload) - CMP_W'(need_u) - CMP_W'(1);

  assign addr_u  = addr_q[ADDR_W-1:3];
  assign hdr_w   = CMP_W'(addr_u) - CMP_W'(1);
  assign gaddr   = {CMP_W'(cur_q) + CMP_W'(1), 3'b000};

  always_comb begin
    sts_o.cfg_ok   = CMP_W'(cfg_u) >= CMP_W'(2);
    sts_o.is_free  = act_q;
    sts_o.req_ok   = (req_q != '0) && ((REQ_W + 1)'(req_q) <= (REQ_W + 1)'(iffa_pkg::MAX_REQUEST));
    sts_o.free_ok  = (addr_q[2:0] == 3'b000) && (addr_u != '0) && (hdr_w < CMP_W'(heap_q));
    sts_o.fit      = !rd_word[0] && (CMP_W'(need_u) <= CMP_W'(payload));
    sts_o.split    = CMP_W'(payload) >= CMP_W'(need_u) + CMP_W'(2);
    sts_o.last     = next_u >= CMP_W'(heap_q);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.fmt_wr) begin
      we    = 1'b1;
      wdata = {IDX_W'(heap_q - UNIT_W'(1)), 1'b0};
    end else if (cmd_i.hit_wr) begin
      we    = 1'b1;
      waddr = cur_q[IDX_W-1:0];
      wdata = sts_o.split ? {IDX_W'(need_u), 1'b1} : {payload, 1'b1};
    end else if (cmd_i.split_wr) begin
      we    = 1'b1;
      waddr = nidx_q;
      wdata = {rem_q, 1'b0};
    end else if (cmd_i.free_wr) begin
      we    = 1'b1;
      waddr = hdr_w[IDX_W-1:0];
      wdata = {payload, 1'b0};
    end
  end

  always_comb begin
    re    = cmd_i.walk_first || cmd_i.walk_next || cmd_i.free_rd;
    raddr = '0;
    if (cmd_i.walk_next) begin
      raddr = next_u[IDX_W-1:0];
    end else if (cmd_i.free_rd) begin
      raddr = hdr_w[IDX_W-1:0];
    end
  end

  iffa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (iffa_pkg::STORE_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= UNIT_W'(iffa_pkg::STORE_DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_load && sts_o.cfg_ok) begin
        heap_q <= cfg_clip;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      act_q   <= action_i;
      req_q   <= request_size_i;
      addr_q  <= block_address_i;
      grant_q <= 1'b0;
    end
    if (cmd_i.walk_first) begin
      cur_q <= '0;
    end else if (cmd_i.walk_next) begin
      cur_q <= UNIT_W'(next_u);
    end
    if (cmd_i.hit_wr) begin
      grant_q <= 1'b1;
      rem_q   <= rem_w[IDX_W-1:0];
      nidx_q  <= nidx_w[IDX_W-1:0];
    end
    if (cmd_i.load_result) begin
      out_grant_q <= grant_q;
      out_addr_q  <= grant_q ? gaddr[ADDR_W-1:0] : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign granted_o         = out_grant_q;

endmodule

`default_nettype wire

### hw/rtl/implicit_list_first_fit_allocator_core.sv
// Top level of the implicit-list first-fit heap allocator.
// Depends on iffa_pkg, iffa_ctrl, iffa_dp (which holds iffa_ram).
//
//   channel  | direction | tdata / data            | tuser
//   s_axis   | in        | request_size, block_adr | action (0 alloc, 1 free)
//   m_axis   | out       | granted_address         | granted
//   cfg      | in        | heap length in bytes    | -
//
// Allocate: start, one walk step per header visited, a split step when the
// block is split, then the response; the walk reads one header per cycle from
// the header RAM, so up to heap length/8 headers. Free: start, header write
// and response; an ignored address skips the write. After reset and after each
// accepted heap length write of 16 or more, state FMT formats the heap.
// A finished item waits until the output register is free; the next item is
// taken while a result still waits on m_axis.
`default_nettype none

module implicit_list_first_fit_allocator_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] request_size, [27:16] block_address, [31:28] zero
  input  wire logic [iffa_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [11:0] granted_address, [15:12] zero
  output logic [iffa_pkg::M_DATA_W-1:0]        m_axis_tdata,
  // [0] granted
  output logic                                 m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  // [12:0] heap length in bytes, [15:13] unused
  input  wire logic [iffa_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  iffa_pkg::ctrl_cmd_t cmd;
  iffa_pkg::ctrl_sts_t sts;
  logic [iffa_pkg::ADDR_W-1:0] granted_address;

  iffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .s_ready_o   (s_axis_tready),
    .cfg_ready_o (cfg_ready_o)
  );

  iffa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_data_i        (cfg_data_i),
    .action_i          (s_axis_tuser),
    .request_size_i    (s_axis_tdata[iffa_pkg::REQ_W-1:0]),
    .block_address_i   (s_axis_tdata[iffa_pkg::REQ_W+iffa_pkg::ADDR_W-1:iffa_pkg::REQ_W]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .granted_address_o (granted_address),
    .granted_o         (m_axis_tuser)
  );

  assign m_axis_tdata = {{(iffa_pkg::M_DATA_W - iffa_pkg::ADDR_W){1'b0}}, granted_address};

`ifndef SYNTH
  a_no_dual_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready && cfg_valid_i && cfg_ready_o))
    else $error("item and config transaction in the same cycle");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !cfg_ready_o))
    else $error("ready while an item is in progress");

  a_grant_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[2:0] == 3'b000 && m_axis_tdata[11:0] != 12'd0))
    else $error("granted address not a valid payload offset");

  a_nogrant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[11:0] == 12'd0))
    else $error("nonzero address without grant");
`endif

endmodule

`default_nettype wire

### test/iffa_grant_checker.sv
// Operation codes for the allocator bench and the checker that mirrors the heap headers.
// Depends on iffa_pkg; instantiated by implicit_list_first_fit_allocator_core_tb.

package iffa_tb_pkg;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } heap_op_e;

  localparam int HDR_BYTES = 8;
  localparam int MIN_SPLIT = 16;

endpackage

module iffa_grant_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  // [15:0] request_size, [27:16] block_address, [31:28] zero
  input  wire logic [iffa_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // [0] action
  input  wire logic                            s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [11:0] granted_address, [15:12] zero
  input  wire logic [iffa_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] granted
  input  wire logic                            m_axis_tuser,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_o,
  input  wire logic [iffa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                          mismatch_o,
  output int unsigned                          pending_o,
  output int unsigned                          heap_bytes_o
);

  localparam int WORDS     = iffa_pkg::STORE_DEPTH;
  localparam int HDR_BYTES = iffa_tb_pkg::HDR_BYTES;
  localparam int MIN_SPLIT = iffa_tb_pkg::MIN_SPLIT;

  typedef struct packed {
    logic [iffa_pkg::ADDR_W-1:0] adr;
    logic                        granted;
  } grant_t;

  int unsigned shadow_hdr [WORDS];
  int unsigned heap_bytes;
  int unsigned mismatches = 0;
  grant_t      expected_grants [$];

  assign mismatch_o   = mismatches;
  assign heap_bytes_o = heap_bytes;

  task automatic format_heap();
    shadow_hdr[0] = (heap_bytes - HDR_BYTES) & ~32'd1;
  endtask

  task automatic write_heap_size(input logic [iffa_pkg::CFG_DATA_W-1:0] raw);
    int unsigned bytes;
    bytes = 32'(raw[iffa_pkg::HEAP_W-1:0]);
    bytes = bytes & ~32'd7;
    if (bytes > iffa_pkg::HEAP_BYTES) bytes = iffa_pkg::HEAP_BYTES;
    if (bytes >= MIN_SPLIT) begin
      heap_bytes = bytes;
      format_heap();
    end
  endtask

  // walks the chain from offset 0, returns the payload offset or 0
  function automatic int unsigned first_fit_grant(input int unsigned req);
    int unsigned cur;
    int unsigned need;
    int unsigned word;
    int unsigned payload;
    int unsigned nxt;
    cur = 0;
    if (req == 0 || req > iffa_pkg::MAX_REQUEST) return 0;
    need = (req + 7) & ~32'd7;
    while (cur < heap_bytes && (cur >> 3) < WORDS) begin
      word    = shadow_hdr[cur >> 3];
      payload = word & ~32'd1;
      if (!word[0] && need <= payload) begin
        if (payload >= need + MIN_SPLIT) begin
          shadow_hdr[cur >> 3] = need | 32'd1;
          nxt = (cur + HDR_BYTES + need) >> 3;
          if (nxt < WORDS) shadow_hdr[nxt] = (payload - HDR_BYTES - need) & ~32'd1;
        end else begin
          shadow_hdr[cur >> 3] = payload | 32'd1;
        end
        return cur + HDR_BYTES;
      end
      cur = cur + HDR_BYTES + payload;
    end
    return 0;
  endfunction

  task automatic release_block(input int unsigned adr);
    int unsigned hdr;
    if (adr < HDR_BYTES || (adr & 7) != 0) return;
    hdr = adr - HDR_BYTES;
    if (hdr >= heap_bytes || (hdr >> 3) >= WORDS) return;
    shadow_hdr[hdr >> 3] = shadow_hdr[hdr >> 3] & ~32'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track_proc
    grant_t      got;
    grant_t      want;
    int unsigned offs;
    if (!rst_ni) begin
      foreach (shadow_hdr[k]) shadow_hdr[k] = 0;
      heap_bytes = iffa_pkg::HEAP_BYTES;
      format_heap();
      expected_grants.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) write_heap_size(cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.adr     = m_axis_tdata[iffa_pkg::ADDR_W-1:0];
        got.granted = m_axis_tuser;
        if (expected_grants.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result adr %0d granted %0b", $realtime, got.adr,
                     got.granted);
        end else begin
          want = expected_grants.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected adr %0d granted %0b, got adr %0d granted %0b",
                       $realtime, want.adr, want.granted, got.adr, got.granted);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        offs = 0;
        if (s_axis_tuser == iffa_tb_pkg::OP_FREE) release_block(32'(s_axis_tdata[27:16]));
        else offs = first_fit_grant(32'(s_axis_tdata[15:0]));
        want.adr     = offs[iffa_pkg::ADDR_W-1:0];
        want.granted = (offs != 0);
        expected_grants.push_back(want);
      end
      pending_o <= expected_grants.size();
    end
  end

endmodule

### test/implicit_list_first_fit_allocator_core_tb.sv
// Top bench for the first-fit heap allocator: clock, reset, stimulus and verdict.
// Depends on iffa_pkg, iffa_tb_pkg and iffa_grant_checker (in iffa_grant_checker.sv).

module implicit_list_first_fit_allocator_core_tb;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 127;
  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 16;

  localparam iffa_tb_pkg::heap_op_e OP_ALLOC = iffa_tb_pkg::OP_ALLOC;
  localparam iffa_tb_pkg::heap_op_e OP_FREE  = iffa_tb_pkg::OP_FREE;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [iffa_pkg::S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                            s_axis_tuser  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [iffa_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [iffa_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned heap_bytes;

  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  bit          steady_phase = 1'b0;
  int unsigned sent         = 0;
  int unsigned results      = 0;
  int unsigned grants       = 0;
  int unsigned heap_writes  = 0;

  logic [iffa_pkg::ADDR_W-1:0] live_q [$];
  logic [iffa_pkg::ADDR_W-1:0] seen_q [$];
  bit                          seen_map [iffa_pkg::STORE_DEPTH];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  implicit_list_first_fit_allocator_core i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  iffa_grant_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .mismatch_o   (mismatches),
    .pending_o    (pending),
    .heap_bytes_o (heap_bytes)
  );

  // granted addresses feed the free stimulus
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results++;
      if (m_axis_tuser) begin
        grants++;
        live_q.push_back(m_axis_tdata[iffa_pkg::ADDR_W-1:0]);
        if (!seen_map[m_axis_tdata[iffa_pkg::ADDR_W-1:3]]) begin
          seen_map[m_axis_tdata[iffa_pkg::ADDR_W-1:3]] = 1'b1;
          seen_q.push_back(m_axis_tdata[iffa_pkg::ADDR_W-1:0]);
        end
      end
    end
  end

  initial begin : result_sink
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!steady_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_item(input iffa_tb_pkg::heap_op_e op, input logic [15:0] req,
                           input logic [iffa_pkg::ADDR_W-1:0] adr);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, adr, req};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    if (!steady_phase && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_heap(input logic [15:0] raw);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= raw;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    heap_writes++;
    live_q.delete();
  endtask

  task automatic rand_item();
    int unsigned                 sel;
    int unsigned                 pick;
    int                          idx;
    logic [15:0]                 req;
    logic [iffa_pkg::ADDR_W-1:0] adr;
    sel  = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    req  = 16'($urandom());
    adr  = 12'($urandom());
    if (sel < 55 || (live_q.size() == 0 && sel < 80)) begin
      if (pick < 60) req = 16'($urandom_range(1, 48));
      else if (pick < 80) req = 16'($urandom_range(1, 256));
      else if (pick < 88) req = 16'($urandom_range(257, 4096));
      else if (pick < 93) req = '0;
      else if (pick < 97) req = 16'($urandom_range(4097, 65535));
      send_item(OP_ALLOC, req, adr);
    end else begin
      if (pick < 65 && live_q.size() != 0) begin
        idx = $urandom_range(0, live_q.size() - 1);
        adr = live_q[idx];
        live_q.delete(idx);
      end else if (pick < 78 && seen_q.size() != 0) begin
        adr = seen_q[$urandom_range(0, seen_q.size() - 1)];
      end else if (pick < 84) begin
        adr = '0;
      end else if (pick < 90 && heap_bytes <= 4080) begin
        // header lies past the end of the heap
        adr = 12'(8 * $urandom_range(heap_bytes / 8 + 1, 511));
      end else begin
        adr[2:0] = 3'($urandom_range(1, 7));
      end
      send_item(OP_FREE, req, adr);
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_heap [PHASES];
    phase_heap = '{16'h1000, 16'd40, 16'($urandom_range(16, 1024)), 16'hE0CB,
                   16'($urandom_range(0, 15)), 16'($urandom()),
                   16'($urandom_range(1024, 4096)), 16'd16, 16'h1FFF};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full heap after reset
    send_item(OP_ALLOC, 16'd0, 12'd0);
    send_item(OP_ALLOC, 16'd4097, 12'd0);
    send_item(OP_ALLOC, 16'hFFFF, 12'hFFF);
    send_item(OP_ALLOC, 16'd4096, 12'd0);
    send_item(OP_ALLOC, 16'd4088, 12'd0);
    send_item(OP_ALLOC, 16'd1, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd8);
    send_item(OP_ALLOC, 16'd4080, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd8);
    send_item(OP_ALLOC, 16'd4072, 12'd0);
    send_item(OP_ALLOC, 16'd8, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd5);
    send_item(OP_FREE, 16'd0, 12'hFFF);
    send_item(OP_FREE, 16'd0, 12'd8);
    send_item(OP_ALLOC, 16'd1, 12'd0);
    send_item(OP_FREE, 16'hFFFF, 12'd4088);

    set_heap(16'd16);
    send_item(OP_ALLOC, 16'd8, 12'd0);
    send_item(OP_ALLOC, 16'd1, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd4088);

    // free of a stale header word left from the larger heap
    set_heap(16'd64);
    send_item(OP_ALLOC, 16'd16, 12'd0);
    send_item(OP_FREE, 16'd0, 12'd24);

    set_heap(16'd8);
    set_heap(16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      set_heap(phase_heap[p]);
      steady_phase = (p == PHASES - 1);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 0 && k == 30) hold_req = 1'b1;
        rand_item();
      end
    end
    wait_idle();

    $display("Summary: %0d requests, %0d results, %0d grants, %0d heap resizes",
             sent, results, grants, heap_writes);
    $display("Run included a long output hold-off and a final stretch with no idle cycles.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### implicit_list_first_fit_allocator_core.f
hw/rtl/iffa_pkg.sv
hw/rtl/iffa_ram.sv
hw/rtl/iffa_ctrl.sv
hw/rtl/iffa_dp.sv
hw/rtl/implicit_list_first_fit_allocator_core.sv
test/iffa_grant_checker.sv
test/implicit_list_first_fit_allocator_core_tb.sv
